### hw/rtl/char_to_glyph_lookup_top_macros.svh
// ----------------------------------------------------------------------------
// char_to_glyph_lookup_top_macros.svh
// Assertion macros used by the checker file of the glyph lookup block.
// ----------------------------------------------------------------------------
`ifndef CHAR_TO_GLYPH_LOOKUP_TOP_MACROS_SVH
`define CHAR_TO_GLYPH_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, masked during reset
`define C2G_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked during reset
`define C2G_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define C2G_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/c2g_pkg.sv
// ----------------------------------------------------------------------------
// c2g_pkg
// Shared constants and types of the character-to-glyph lookup block.
// ----------------------------------------------------------------------------
package c2g_pkg;

    // Font store size and address widths
    localparam int FONT_BYTES = 65536;
    localparam int ADDR_W     = $clog2(FONT_BYTES);
    // Wide enough for any table address a lookup can form
    localparam int OFS_W      = (ADDR_W + 1 > 21) ? ADDR_W + 1 : 21;

    // Field widths
    localparam int SUB_W   = 16;
    localparam int LEN_W   = 17;
    localparam int CP_W    = 32;
    localparam int GID_W   = 16;
    localparam int CFG_W   = 17;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Register indexes
    localparam logic REG_SUBTABLE = 1'b0;
    localparam logic REG_LENGTH   = 1'b1;

    // Subtable formats
    localparam logic [15:0] FMT_SEG   = 16'd4;
    localparam logic [15:0] FMT_GROUP = 16'd12;

    // Result status
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FMT    = 2'd1,
        ST_NOCMAP = 2'd2
    } t_status;

endpackage

### hw/rtl/c2g_in_if.sv
// ----------------------------------------------------------------------------
// c2g_in_if
// Input channel: font byte writes and codepoint lookups.
// ----------------------------------------------------------------------------
interface c2g_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic [31:0] codepoint;

    modport source (output valid, op, write_address, write_byte, codepoint, input ready);
    modport sink   (input valid, op, write_address, write_byte, codepoint, output ready);
endinterface

### hw/rtl/c2g_out_if.sv
// ----------------------------------------------------------------------------
// c2g_out_if
// Output channel: lookup status and glyph index.
// ----------------------------------------------------------------------------
interface c2g_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] glyph_id;

    modport source (output valid, status, glyph_id, input ready);
    modport sink   (input valid, status, glyph_id, output ready);
endinterface

### hw/rtl/c2g_ram.sv
// ----------------------------------------------------------------------------
// c2g_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module c2g_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

### hw/rtl/char_to_glyph_lookup_top.sv
// ----------------------------------------------------------------------------
// char_to_glyph_lookup_top
// Maps codepoints to glyph indexes by walking a format 4 or format 12
// character map subtable held in an on-chip font byte store.
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    op, write_address, write_byte, codepoint
//   o_out     out   valid/ready    status, glyph_id
//   cfg       in    i_cfg_we       i_cfg_idx, i_cfg_data
//
// A lookup reads the store one byte a cycle through its single port,
// fetching each field in the read state and then acting on it in the
// state that asked for it. One lookup is in flight at a time; the result
// register lets the next item in while the last result waits. Input ready
// is low during reset. Reset clears control and configuration registers
// only; the payload registers and the store are not cleared.
// ----------------------------------------------------------------------------
module char_to_glyph_lookup_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    c2g_in_if.sink                   i_in,
    c2g_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [c2g_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int OW = c2g_pkg::OFS_W;
    localparam int AW = c2g_pkg::ADDR_W;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_RD      = 14'b00000000000010,
        S_FMT     = 14'b00000000000100,
        S_F4_NSEG = 14'b00000000001000,
        S_F4_END  = 14'b00000000010000,
        S_F4_STRT = 14'b00000000100000,
        S_F4_DLT  = 14'b00000001000000,
        S_F4_ROFS = 14'b00000010000000,
        S_F4_GLY  = 14'b00000100000000,
        S_F12_NG  = 14'b00001000000000,
        S_F12_FST = 14'b00010000000000,
        S_F12_LST = 14'b00100000000000,
        S_F12_BAS = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } t_state;

    // Control
    t_state r_state, n_state, r_ret, n_ret;
    logic [2:0]  r_left, n_left;
    logic        r_pend, n_pend;
    logic        r_out_valid, n_out_valid;
    // Configuration
    logic [c2g_pkg::SUB_W-1:0] r_sub;
    logic [c2g_pkg::LEN_W-1:0] r_len;
    // Datapath
    logic [OW-1:0] r_addr, n_addr, r_ptr, n_ptr, r_sa, n_sa;
    logic [31:0]   r_acc, n_acc, r_cnt, n_cnt, r_cp, n_cp, r_first, n_first;
    logic [15:0]   r_seg2, n_seg2, r_endc, n_endc, r_startc, n_startc;
    logic [15:0]   r_delta, n_delta;
    c2g_pkg::t_status r_fst, n_fst, r_ost, n_ost;
    logic [15:0]   r_fgid, n_fgid, r_ogid, n_ogid;

    // Field fetch launch request
    logic          l_go;
    logic [OW-1:0] l_addr;
    logic [2:0]    l_n;
    t_state        l_ret;
    // Finish request
    logic             f_go;
    c2g_pkg::t_status f_st;
    logic [15:0]      f_gid;

    logic [OW-1:0] lim, wa_ext, sub_ext, gpos;
    logic [15:0]   cp_diff;
    logic [32:0]   gsum;
    logic          in_acc, ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;

    assign sub_ext = OW'(r_sub);
    assign wa_ext  = OW'(i_in.write_address);
    assign lim     = (OW'(r_len) > OW'(c2g_pkg::FONT_BYTES)) ? OW'(c2g_pkg::FONT_BYTES)
                                                             : OW'(r_len);
    assign cp_diff = r_cp[15:0] - r_startc;
    assign gpos    = r_sa + OW'(r_acc[15:0]) + OW'({cp_diff, 1'b0});
    assign gsum    = {1'b0, r_acc} + {1'b0, r_cp - r_first};

    assign i_in.ready     = i_rst_n && (r_state == S_IDLE);
    assign in_acc         = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_ost;
    assign o_out.glyph_id = r_ogid;

    // Store port: writes in idle, field reads otherwise
    assign ram_we   = in_acc && (i_in.op == c2g_pkg::OP_WRITE)
                      && (wa_ext < OW'(c2g_pkg::FONT_BYTES));
    assign ram_addr = (r_state == S_IDLE) ? wa_ext[AW-1:0] : r_addr[AW-1:0];

    c2g_ram #(.WIDTH(8), .DEPTH(c2g_pkg::FONT_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.write_byte),
        .o_rdata (ram_rdata)
    );

    // Walk the subtable
    always_comb begin
        n_state = r_state; n_ret = r_ret; n_left = r_left; n_pend = r_pend;
        n_addr = r_addr; n_ptr = r_ptr; n_sa = r_sa; n_acc = r_acc; n_cnt = r_cnt;
        n_cp = r_cp; n_first = r_first; n_seg2 = r_seg2; n_endc = r_endc;
        n_startc = r_startc; n_delta = r_delta; n_fst = r_fst; n_fgid = r_fgid;
        n_ost = r_ost; n_ogid = r_ogid;
        n_out_valid = r_out_valid && !o_out.ready;
        l_go = 1'b0; l_addr = '0; l_n = 3'd2; l_ret = S_FMT;
        f_go = 1'b0; f_st = c2g_pkg::ST_OK; f_gid = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.op == c2g_pkg::OP_LOOKUP)) begin
                    n_cp = i_in.codepoint;
                    l_go = 1'b1; l_addr = sub_ext; l_n = 3'd2; l_ret = S_FMT;
                end
            end
            S_RD: begin
                if (r_pend) begin
                    n_acc = {r_acc[23:0], ram_rdata};
                end
                if (r_left != 3'd0) begin
                    n_addr = r_addr + OW'(1);
                    n_left = r_left - 3'd1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = r_ret;
                end
            end
            S_FMT: begin
                if (r_acc[15:0] == c2g_pkg::FMT_SEG) begin
                    if (r_cp[31:16] != 16'd0) begin
                        f_go = 1'b1;
                    end else begin
                        l_go = 1'b1; l_addr = sub_ext + OW'(6); l_ret = S_F4_NSEG;
                    end
                end else if (r_acc[15:0] == c2g_pkg::FMT_GROUP) begin
                    l_go = 1'b1; l_addr = sub_ext + OW'(12); l_n = 3'd4; l_ret = S_F12_NG;
                end else begin
                    f_go = 1'b1; f_st = c2g_pkg::ST_NOCMAP;
                end
            end
            S_F4_NSEG: begin
                n_seg2 = {r_acc[15:1], 1'b0};
                n_cnt  = 32'(r_acc[15:1]);
                n_ptr  = sub_ext + OW'(14);
                if (r_acc[15:1] == 15'd0) begin
                    f_go = 1'b1; f_st = c2g_pkg::ST_FMT;
                end else begin
                    l_go = 1'b1; l_addr = sub_ext + OW'(14); l_ret = S_F4_END;
                end
            end
            S_F4_END: begin
                n_endc = r_acc[15:0];
                n_sa   = r_ptr + OW'(2) + OW'(r_seg2);
                l_go = 1'b1; l_addr = r_ptr + OW'(2) + OW'(r_seg2); l_ret = S_F4_STRT;
            end
            S_F4_STRT: begin
                n_startc = r_acc[15:0];
                if ((r_cp[15:0] < r_acc[15:0]) || (r_cp[15:0] > r_endc)) begin
                    // Miss: step to the next segment
                    if (r_cnt == 32'd1) begin
                        f_go = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 32'd1;
                        n_ptr = r_ptr + OW'(2);
                        l_go = 1'b1; l_addr = r_ptr + OW'(2); l_ret = S_F4_END;
                    end
                end else begin
                    n_sa = r_sa + OW'(r_seg2);
                    l_go = 1'b1; l_addr = r_sa + OW'(r_seg2); l_ret = S_F4_DLT;
                end
            end
            S_F4_DLT: begin
                n_delta = r_acc[15:0];
                n_sa    = r_sa + OW'(r_seg2);
                l_go = 1'b1; l_addr = r_sa + OW'(r_seg2); l_ret = S_F4_ROFS;
            end
            S_F4_ROFS: begin
                if (r_acc[15:0] == 16'd0) begin
                    f_go = 1'b1; f_gid = r_cp[15:0] + r_delta;
                end else begin
                    l_go = 1'b1; l_addr = gpos; l_ret = S_F4_GLY;
                end
            end
            S_F4_GLY: begin
                f_go  = 1'b1;
                f_gid = (r_acc[15:0] == 16'd0) ? 16'd0 : r_acc[15:0] + r_delta;
            end
            S_F12_NG: begin
                n_cnt = r_acc;
                n_ptr = sub_ext + OW'(16);
                if (r_acc == 32'd0) begin
                    f_go = 1'b1;
                end else begin
                    l_go = 1'b1; l_addr = sub_ext + OW'(16); l_n = 3'd4; l_ret = S_F12_FST;
                end
            end
            S_F12_FST: begin
                n_first = r_acc;
                l_go = 1'b1; l_addr = r_ptr + OW'(4); l_n = 3'd4; l_ret = S_F12_LST;
            end
            S_F12_LST: begin
                if ((r_cp < r_first) || (r_cp > r_acc)) begin
                    // Miss: step to the next group
                    if (r_cnt == 32'd1) begin
                        f_go = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 32'd1;
                        n_ptr = r_ptr + OW'(12);
                        l_go = 1'b1; l_addr = r_ptr + OW'(12); l_n = 3'd4; l_ret = S_F12_FST;
                    end
                end else begin
                    l_go = 1'b1; l_addr = r_ptr + OW'(8); l_n = 3'd4; l_ret = S_F12_BAS;
                end
            end
            S_F12_BAS: begin
                f_go = 1'b1;
                if (gsum[32:16] != 17'd0) begin
                    f_st = c2g_pkg::ST_FMT;
                end else begin
                    f_gid = gsum[15:0];
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_ost       = r_fst;
                    n_ogid      = r_fgid;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Launch a field fetch after its bounds check
        if (l_go) begin
            if (l_addr + OW'(l_n) > lim) begin
                f_go = 1'b1; f_st = c2g_pkg::ST_FMT;
            end else begin
                n_addr  = l_addr;
                n_left  = l_n;
                n_pend  = 1'b0;
                n_acc   = '0;
                n_ret   = l_ret;
                n_state = S_RD;
            end
        end
        if (f_go) begin
            n_fst   = f_st;
            n_fgid  = (f_st == c2g_pkg::ST_OK) ? f_gid : 16'd0;
            n_state = S_DONE;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_FMT;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_sub       <= '0;
            r_len       <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    c2g_pkg::REG_SUBTABLE: r_sub <= i_cfg_data[c2g_pkg::SUB_W-1:0];
                    c2g_pkg::REG_LENGTH:   r_len <= i_cfg_data[c2g_pkg::LEN_W-1:0];
                    default:               r_len <= r_len;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_ptr    <= n_ptr;
        r_sa     <= n_sa;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_cp     <= n_cp;
        r_first  <= n_first;
        r_seg2   <= n_seg2;
        r_endc   <= n_endc;
        r_startc <= n_startc;
        r_delta  <= n_delta;
        r_fst    <= n_fst;
        r_fgid   <= n_fgid;
        r_ost    <= n_ost;
        r_ogid   <= n_ogid;
    end

endmodule

### hw/rtl/c2g_checker.sv
// ----------------------------------------------------------------------------
// c2g_checker
// Port-level checks of the glyph lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_to_glyph_lookup_top_macros.svh"

module c2g_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [15:0] i_out_glyph
);

    // Failed lookups carry glyph zero
    `C2G_ASSERT_NOW(a_err_glyph_zero, i_out_valid && (i_out_status != c2g_pkg::ST_OK), i_out_glyph == 16'd0)
    // Reset empties the result register
    `C2G_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !i_out_valid)
    // A waiting result is not dropped
    `C2G_ASSERT_NEXT(a_result_holds, i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind char_to_glyph_lookup_top c2g_checker u_c2g_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_glyph  (o_out.glyph_id)
);

### sim/char_to_glyph_lookup_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_to_glyph_lookup_top_tb
// Loads a small font image with format 4 and format 12 character maps, then
// runs directed and random codepoint lookups under several subtable offset
// and font length settings. A scoreboard mirrors the font store, predicts each
// lookup and checks every result in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module char_to_glyph_lookup_top_tb;

    localparam int REGION     = 384;     // bytes written before any lookup
    localparam int SETTLE     = 200;     // settling wait after the results are back
    localparam int IDLE_LIMIT = 100000;  // cycles with no item moving

    typedef struct packed {
        c2g_pkg::t_status st;
        logic [15:0]      gid;
    } t_glyph_result;

    // Mirror of the font store and registers; predicts and checks lookups
    class glyph_scoreboard;
        logic [7:0]          font_mem [0:65535];
        bit                  font_known [0:65535];
        logic [15:0]         sub_ofs;
        logic [16:0]         font_len;
        bit                  touched_unknown;
        t_glyph_result       pending_q [$];
        int                  errors;
        int                  n_writes;
        int                  n_lookups;
        int                  n_status [3];

        function new();
            sub_ofs  = '0;
            font_len = '0;
            errors   = 0;
            n_writes = 0;
            n_lookups = 0;
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [16:0] data);
            if (idx == c2g_pkg::REG_SUBTABLE) sub_ofs = data[15:0];
            else font_len = data;
        endfunction

        // Big-endian read, bounded by the font length
        function bit fetch_be(longint unsigned off, int n, output logic [31:0] v);
            longint unsigned lim;
            v = '0;
            lim = (font_len > 17'd65536) ? 64'd65536 : 64'(font_len);
            if (off + n > lim) return 0;
            for (int k = 0; k < n; k++) begin
                if (!font_known[off + k]) touched_unknown = 1;
                v = {v[23:0], font_mem[off + k]};
            end
            return 1;
        endfunction

        function c2g_pkg::t_status walk_segments(longint unsigned sub, logic [31:0] cp,
                                                 output logic [15:0] gid);
            logic [31:0] segx2, endc, startc, delta, rofs, g;
            longint unsigned seg, ra, gpos;
            gid = '0;
            if (cp > 32'hFFFF) return c2g_pkg::ST_OK;
            if (!fetch_be(sub + 6, 2, segx2)) return c2g_pkg::ST_FMT;
            seg = segx2 / 2;
            if (seg == 0) return c2g_pkg::ST_FMT;
            for (longint unsigned i = 0; i < seg; i++) begin
                ra = sub + 16 + seg * 6 + i * 2;
                if (!fetch_be(sub + 14 + i * 2, 2, endc)) return c2g_pkg::ST_FMT;
                if (!fetch_be(sub + 16 + seg * 2 + i * 2, 2, startc)) return c2g_pkg::ST_FMT;
                if (cp < startc || cp > endc) continue;
                if (!fetch_be(sub + 16 + seg * 4 + i * 2, 2, delta)) return c2g_pkg::ST_FMT;
                if (!fetch_be(ra, 2, rofs)) return c2g_pkg::ST_FMT;
                if (rofs == 0) begin
                    gid = 16'(cp + delta);
                    return c2g_pkg::ST_OK;
                end
                gpos = ra + rofs + 2 * longint'(cp - startc);
                if (!fetch_be(gpos, 2, g)) return c2g_pkg::ST_FMT;
                gid = (g != 0) ? 16'(g + delta) : 16'd0;
                return c2g_pkg::ST_OK;
            end
            return c2g_pkg::ST_OK;
        endfunction

        function c2g_pkg::t_status walk_groups(longint unsigned sub, logic [31:0] cp,
                                               output logic [15:0] gid);
            logic [31:0] ng, g_first, g_last, base;
            longint unsigned rec, g;
            gid = '0;
            if (!fetch_be(sub + 12, 4, ng)) return c2g_pkg::ST_FMT;
            for (longint unsigned i = 0; i < ng; i++) begin
                rec = sub + 16 + i * 12;
                if (!fetch_be(rec, 4, g_first) || !fetch_be(rec + 4, 4, g_last))
                    return c2g_pkg::ST_FMT;
                if (cp < g_first || cp > g_last) continue;
                if (!fetch_be(rec + 8, 4, base)) return c2g_pkg::ST_FMT;
                g = longint'(base) + longint'(cp - g_first);
                if (g > 65535) return c2g_pkg::ST_FMT;
                gid = 16'(g);
                return c2g_pkg::ST_OK;
            end
            return c2g_pkg::ST_OK;
        endfunction

        // Expected result of one lookup; flags reads of never-written bytes
        function t_glyph_result map_glyph(logic [31:0] cp, output bit unknown);
            t_glyph_result r;
            logic [31:0] fmt;
            touched_unknown = 0;
            r.gid = '0;
            if (!fetch_be(sub_ofs, 2, fmt)) r.st = c2g_pkg::ST_FMT;
            else if (fmt[15:0] == c2g_pkg::FMT_SEG) r.st = walk_segments(sub_ofs, cp, r.gid);
            else if (fmt[15:0] == c2g_pkg::FMT_GROUP) r.st = walk_groups(sub_ofs, cp, r.gid);
            else r.st = c2g_pkg::ST_NOCMAP;
            if (r.st != c2g_pkg::ST_OK) r.gid = '0;
            unknown = touched_unknown;
            return r;
        endfunction

        function void note_item(logic op, logic [15:0] addr, logic [7:0] b,
                                logic [31:0] cp);
            bit unknown;
            if (op == c2g_pkg::OP_WRITE) begin
                font_mem[addr]   = b;
                font_known[addr] = 1;
                n_writes++;
            end else begin
                pending_q.push_back(map_glyph(cp, unknown));
                n_lookups++;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic [1:0] st, logic [15:0] gid);
            t_glyph_result e;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result status=%0d glyph=%0d", st, gid));
            end else begin
                e = pending_q.pop_front();
                if (st !== e.st)
                    report($sformatf("status %0d, expected %0d", st, e.st));
                if (gid !== e.gid)
                    report($sformatf("glyph %0d, expected %0d", gid, e.gid));
                if (e.st <= c2g_pkg::ST_NOCMAP) n_status[e.st]++;
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [c2g_pkg::CFG_W-1:0] i_cfg_data;

    c2g_in_if  in_ch();
    c2g_out_if out_ch();

    char_to_glyph_lookup_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    glyph_scoreboard sb = new();
    bit  no_stall;
    int  idle_cycles;
    int  n_cfg;

    // Current table layout, used to aim codepoints at entries
    int          fmt4_base, fmt12_base, n_seg, n_grp;
    logic [31:0] seg_lo [8], seg_hi [8], grp_lo [8], grp_hi [8];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Track accepted items, check results, and guard against a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check(out_ch.status, out_ch.glyph_id);
            if (in_ch.valid && in_ch.ready)
                sb.note_item(in_ch.op, in_ch.write_address, in_ch.write_byte,
                             in_ch.codepoint);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: hold ready low for a random stall before each result, unless stalls are off
    initial begin
        int w;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            w = no_stall ? 0 : $urandom_range(0, 14);
            out_ch.ready = 1'b0;
            repeat (w) @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Present one item after a random gap (none when stalls are off) and hold it until accepted
    task send_item(logic op, logic [15:0] addr, logic [7:0] b, logic [31:0] cp);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.op            = op;
        in_ch.write_address = addr;
        in_ch.write_byte    = b;
        in_ch.codepoint     = cp;
        in_ch.valid         = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task put8(int addr, logic [7:0] b);
        send_item(c2g_pkg::OP_WRITE, 16'(addr), b, $urandom());
    endtask

    task put16(int addr, logic [15:0] v);
        put8(addr, v[15:8]);
        put8(addr + 1, v[7:0]);
    endtask

    task put32(int addr, logic [31:0] v);
        put16(addr, v[31:16]);
        put16(addr + 2, v[15:0]);
    endtask

    // Drop the last item, then hold off until every expected result is back and the block settles
    task drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task write_reg(logic idx, logic [c2g_pkg::CFG_W-1:0] data);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_reg(idx, data);
        n_cfg++;
    endtask

    // Segment map: ascending ranges, each mapped by delta or through the glyph array at random
    task build_fmt4();
        int ga, lo, hi, ra;
        fmt4_base = 16 + $urandom_range(0, 8);
        n_seg = $urandom_range(1, 6);
        ga = fmt4_base + 16 + 8 * n_seg;
        put16(fmt4_base, c2g_pkg::FMT_SEG);
        put16(fmt4_base + 6, 16'(2 * n_seg));
        hi = -1;
        for (int i = 0; i < n_seg; i++) begin
            lo = hi + 1 + $urandom_range(0, 3000);
            if (lo > 65535) lo = 65535;
            hi = lo + $urandom_range(0, 40);
            if (hi > 65535 || (i == n_seg - 1 && $urandom_range(0, 1))) hi = 65535;
            seg_lo[i] = lo;
            seg_hi[i] = hi;
            ra = fmt4_base + 16 + 6 * n_seg + 2 * i;
            put16(fmt4_base + 14 + 2 * i, 16'(hi));
            put16(fmt4_base + 16 + 2 * n_seg + 2 * i, 16'(lo));
            put16(fmt4_base + 16 + 4 * n_seg + 2 * i, 16'($urandom()));
            put16(ra, $urandom_range(0, 1) ? 16'd0 : 16'(ga + 2 * $urandom_range(0, 10) - ra));
        end
        for (int k = 0; k < 24; k++)
            put16(ga + 2 * k, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom()));
    endtask

    // Group map: narrow ranges at random codepoints, one group with a base near the top
    task build_fmt12();
        longint unsigned lo, hi;
        int big;
        fmt12_base = 168 + $urandom_range(0, 8);
        n_grp = $urandom_range(1, 8);
        big = $urandom_range(0, n_grp - 1);
        put16(fmt12_base, c2g_pkg::FMT_GROUP);
        put32(fmt12_base + 12, n_grp);
        for (int i = 0; i < n_grp; i++) begin
            lo = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom();
            hi = lo + $urandom_range(0, 50);
            if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
            grp_lo[i] = lo;
            grp_hi[i] = hi;
            put32(fmt12_base + 16 + 12 * i, 32'(lo));
            put32(fmt12_base + 20 + 12 * i, 32'(hi));
            put32(fmt12_base + 24 + 12 * i,
                  (i == big) ? 32'(65535 - $urandom_range(0, 3)) : $urandom_range(0, 65535));
        end
    endtask

    function automatic logic [31:0] pick_codepoint();
        int j;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                j = $urandom_range(0, n_seg - 1);
                return seg_lo[j] - 1 + $urandom_range(0, seg_hi[j] - seg_lo[j] + 2);
            end
            3, 4, 5: begin
                j = $urandom_range(0, n_grp - 1);
                return grp_lo[j] - 1 + $urandom_range(0, grp_hi[j] - grp_lo[j] + 2);
            end
            6: return $urandom();
            7: return $urandom_range(0, 65535);
            8: begin
                case ($urandom_range(0, 3))
                    0: return 32'd0;
                    1: return 32'hFFFF;
                    2: return 32'h10000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 16'h2000);
        endcase
    endfunction

    // Send a lookup, skipping codepoints that would read never-written bytes
    task lookup(logic [31:0] cp);
        t_glyph_result r;
        bit unknown;
        r = sb.map_glyph(cp, unknown);
        if (!unknown) send_item(c2g_pkg::OP_LOOKUP, $urandom(), $urandom(), cp);
    endtask

    task random_lookup();
        logic [31:0] cp;
        t_glyph_result r;
        bit unknown;
        for (int t = 0; t < 8; t++) begin
            cp = pick_codepoint();
            r = sb.map_glyph(cp, unknown);
            if (!unknown) begin
                send_item(c2g_pkg::OP_LOOKUP, $urandom(), $urandom(), cp);
                break;
            end
        end
    endtask

    initial begin
        int lens [4];
        int subs [4];
        in_ch.valid         = 1'b0;
        in_ch.op            = c2g_pkg::OP_WRITE;
        in_ch.write_address = '0;
        in_ch.write_byte    = '0;
        in_ch.codepoint     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = c2g_pkg::REG_SUBTABLE;
        i_cfg_data = '0;
        no_stall    = 1'b0;
        idle_cycles = 0;
        n_cfg       = 0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the working region, then lay both maps over it
        for (int a = 0; a < REGION; a++) put8(a, $urandom());
        build_fmt4();
        build_fmt12();

        // Directed: segment map edges and large codepoints
        write_reg(c2g_pkg::REG_LENGTH, REGION);
        write_reg(c2g_pkg::REG_SUBTABLE, fmt4_base);
        lookup(seg_lo[0]);
        lookup(seg_hi[n_seg - 1]);
        lookup(seg_lo[n_seg - 1] + 1);
        lookup(32'd0);
        lookup(32'hFFFF);
        lookup(32'h10000);
        lookup(32'hFFFF_FFFF);

        // Directed: group map edges and glyph overflow
        write_reg(c2g_pkg::REG_SUBTABLE, fmt12_base);
        for (int i = 0; i < n_grp && i < 4; i++) begin
            lookup(grp_lo[i]);
            lookup(grp_hi[i]);
        end
        lookup(32'hFFFF_FFFF);

        // Directed: zero segment count, then restore it
        drain();
        put16(fmt4_base + 6, 16'd1);
        write_reg(c2g_pkg::REG_SUBTABLE, fmt4_base);
        lookup(seg_lo[0]);
        drain();
        put16(fmt4_base + 6, 16'(2 * n_seg));

        // Directed: unsupported format, empty font, truncated table, top offset
        put16(300, 16'd7);
        write_reg(c2g_pkg::REG_SUBTABLE, 300);
        lookup(32'd5);
        write_reg(c2g_pkg::REG_LENGTH, 0);
        lookup(32'd5);
        write_reg(c2g_pkg::REG_LENGTH, fmt4_base + 20);
        write_reg(c2g_pkg::REG_SUBTABLE, 17'h10000 | fmt4_base);
        lookup(seg_lo[0]);
        write_reg(c2g_pkg::REG_LENGTH, 65536);
        lookup(seg_lo[0]);
        write_reg(c2g_pkg::REG_SUBTABLE, 65535);
        lookup(32'd0);

        // Random phases under varied settings; pause for all results each time
        for (int p = 0; p < 8; p++) begin
            no_stall = (p == 3 || p == 5);
            if (p == 2 || p == 6) begin
                drain();
                build_fmt4();
            end
            if (p == 4 || p == 6) begin
                drain();
                build_fmt12();
            end
            lens = '{REGION, 65536, $urandom_range(0, REGION), fmt12_base + $urandom_range(0, 60)};
            subs = '{fmt4_base, fmt12_base, $urandom_range(0, REGION - 1), 65535};
            write_reg(c2g_pkg::REG_LENGTH, lens[(p == 0) ? 0 : $urandom_range(0, 3)]);
            write_reg(c2g_pkg::REG_SUBTABLE, subs[(p < 2) ? p : ($urandom_range(0, 4) % 4)]);
            for (int n = 0; n < 45; n++) begin
                if ($urandom_range(0, 99) < 85)
                    random_lookup();
                else if ($urandom_range(0, 2) == 0)
                    put8($urandom_range(0, REGION - 1), $urandom());
                else
                    put8($urandom_range(1024, 65535), $urandom());
            end
        end

        // Wait for the last results, then let the block settle
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

        $display("covered %0d byte writes, %0d lookups, %0d register writes",
                 sb.n_writes, sb.n_lookups, n_cfg);
        $display("lookup outcomes: ok %0d, format error %0d, unsupported format %0d",
                 sb.n_status[c2g_pkg::ST_OK], sb.n_status[c2g_pkg::ST_FMT],
                 sb.n_status[c2g_pkg::ST_NOCMAP]);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/c2g_pkg.sv
hw/rtl/c2g_in_if.sv
hw/rtl/c2g_out_if.sv
hw/rtl/c2g_ram.sv
hw/rtl/char_to_glyph_lookup_top.sv
hw/rtl/c2g_checker.sv
sim/char_to_glyph_lookup_top_tb.sv
